// ----- hw/rtl/brf_pkg.sv -----
// shared types, codes and constants of the bisection root finder
// no dependencies
`timescale 1ns / 1ps
package brf_pkg;

  localparam int unsigned MAX_ITER_DEF  = 64;
  localparam int unsigned FRAC_BITS_DEF = 24;
  localparam int unsigned DIV_STEPS     = 31;
  localparam logic [30:0] ERR_MAX       = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] left_end;
    logic signed [31:0] right_end;
    logic [30:0]        tolerance;
    logic               error_mode;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] root;
    logic [30:0]        error_estimate;
    logic [6:0]         iterations;
    logic [1:0]         status;
  } res_beat_t;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_EXACT     = 2'd1,
    ST_NO_SIGN   = 2'd2,
    ST_CAP       = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ,
    OP_HI,
    OP_LO,
    OP_CUBE,
    OP_POLY,
    OP_SAVE_A,
    OP_MID,
    OP_UPDATE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FINISH
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_HI,
    S_LO,
    S_CUBE,
    S_POLY,
    S_SAVE_A,
    S_CHECK,
    S_UPDATE,
    S_DIV_INIT,
    S_DIV_STEP,
    S_JUDGE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_M
  } phase_e;

  typedef struct packed {
    dp_op_e  op;
    status_e code;
  } dp_cmd_t;

  typedef struct packed {
    logic f_zero;
    logic no_sign;
    logic need_div;
    logic div_ovf;
    logic err_le_tol;
    logic cap_hit;
  } dp_stat_t;

endpackage

// ----- hw/rtl/brf_dp.sv -----
// datapath: bounds, shared 32x32 multiplier, cubic evaluation, error and divider
// depends on brf_pkg
`timescale 1ns / 1ps
module brf_dp #(
  parameter int unsigned MAX_ITER  = brf_pkg::MAX_ITER_DEF,
  parameter int unsigned FRAC_BITS = brf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  brf_pkg::in_beat_t  in_i,
  input  brf_pkg::dp_cmd_t   cmd_i,
  output brf_pkg::dp_stat_t  stat_o,
  output brf_pkg::res_beat_t res_o
);
  import brf_pkg::*;

  localparam int unsigned HW = 32 - FRAC_BITS;
  localparam int unsigned QW = 39;

  logic signed [31:0] lo_q, hi_q, mid_q, prev_q, x_q;
  logic [30:0]        tol_q, err_q;
  logic               pct_q;
  logic [6:0]         step_q;
  logic               fl_neg_q, fl_zero_q, f_neg_q, f_zero_q;
  logic [63:0]        sq_q, phi_q, plo_q;
  logic [62:0]        c3_q;
  logic [QW-1:0]      q_q;
  logic [31:0]        rem_q;
  logic [30:0]        nsh_q;
  res_beat_t          res_q;

  logic [31:0]        ax, ac, mul_a;
  logic [63:0]        mul_p, part, rest, csum;
  logic [62:0]        c3_d;
  logic signed [63:0] cube, sx, sx7, fval;
  logic [32:0]        msum, diff, d;
  logic [QW-1:0]      q_d;
  logic signed [31:0] mid_d;
  logic [30:0]        err_upd;
  logic               ovf;
  logic [32:0]        t;
  logic               ge;

  assign ax = x_q[31] ? 32'(-{1'b0, x_q}) : 32'(x_q);

  // one shared multiplier, operand picked by the step of the cube
  always_comb begin
    case (cmd_i.op)
      OP_HI:   mul_a = 32'(sq_q[63:32+FRAC_BITS]);
      OP_LO:   mul_a = sq_q[31+FRAC_BITS:FRAC_BITS];
      default: mul_a = ax;
    endcase
  end
  assign mul_p = {32'b0, mul_a} * {32'b0, ax};

  // magnitude of the cube with saturation
  always_comb begin
    part = phi_q << HW;
    rest = plo_q >> FRAC_BITS;
    csum = part + rest;
    if (phi_q >= (64'd1 << (FRAC_BITS - 2))) begin
      c3_d = 63'd1 << 62;
    end else if (csum > (64'd1 << 62)) begin
      c3_d = 63'd1 << 62;
    end else begin
      c3_d = csum[62:0];
    end
  end

  always_comb begin
    cube = x_q[31] ? -$signed({1'b0, c3_q}) : $signed({1'b0, c3_q});
    sx   = 64'(x_q);
    sx7  = (sx <<< 3) - sx;
    fval = cube - sx7 + (64'sd1 <<< FRAC_BITS);
  end

  assign msum  = {lo_q[31], lo_q} + {hi_q[31], hi_q};
  assign mid_d = msum[32:1];

  assign diff = {mid_q[31], mid_q} - {prev_q[31], prev_q};
  assign d    = diff[32] ? -diff : diff;
  assign q_d  = (QW'(d) << 6) + (QW'(d) << 5) + (QW'(d) << 2);
  assign ac   = mid_q[31] ? 32'(-{1'b0, mid_q}) : 32'(mid_q);

  always_comb begin
    if (!pct_q) begin
      err_upd = (d > 33'(ERR_MAX)) ? ERR_MAX : d[30:0];
    end else begin
      err_upd = (q_d > QW'(ERR_MAX)) ? ERR_MAX : q_d[30:0];
    end
  end

  assign ovf = {25'b0, q_q} >= ({32'b0, ac} << (31 - FRAC_BITS));
  assign t   = {rem_q, nsh_q[30]};
  assign ge  = t >= {1'b0, ac};

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        lo_q   <= in_i.left_end;
        hi_q   <= in_i.right_end;
        prev_q <= in_i.left_end;
        x_q    <= in_i.left_end;
        mid_q  <= '0;
        tol_q  <= in_i.tolerance;
        pct_q  <= in_i.error_mode;
        step_q <= '0;
        err_q  <= '0;
      end
      OP_SQ:   sq_q  <= mul_p;
      OP_HI:   phi_q <= mul_p;
      OP_LO:   plo_q <= mul_p;
      OP_CUBE: c3_q  <= c3_d;
      OP_POLY: begin
        f_neg_q  <= fval[63];
        f_zero_q <= (fval == 64'sd0);
      end
      OP_SAVE_A: begin
        fl_neg_q  <= f_neg_q;
        fl_zero_q <= f_zero_q;
        x_q       <= hi_q;
      end
      OP_MID: begin
        mid_q  <= mid_d;
        x_q    <= mid_d;
        step_q <= step_q + 7'd1;
      end
      OP_UPDATE: begin
        if (!fl_zero_q && (fl_neg_q != f_neg_q)) begin
          hi_q <= mid_q;
        end else begin
          lo_q      <= mid_q;
          fl_neg_q  <= f_neg_q;
          fl_zero_q <= f_zero_q;
        end
        q_q    <= q_d;
        err_q  <= err_upd;
        prev_q <= mid_q;
      end
      OP_DIV_INIT: begin
        rem_q <= 32'(({25'b0, q_q}) >> (31 - FRAC_BITS));
        nsh_q <= 31'(({25'b0, q_q}) << FRAC_BITS);
        err_q <= ovf ? ERR_MAX : '0;
      end
      OP_DIV_STEP: begin
        rem_q <= ge ? 32'(t - {1'b0, ac}) : t[31:0];
        nsh_q <= nsh_q << 1;
        err_q <= {err_q[29:0], ge};
      end
      OP_FINISH: begin
        res_q.status <= cmd_i.code;
        if (cmd_i.code == ST_NO_SIGN) begin
          res_q.root           <= '0;
          res_q.error_estimate <= '0;
          res_q.iterations     <= '0;
        end else begin
          res_q.root           <= mid_q;
          res_q.error_estimate <= (cmd_i.code == ST_EXACT) ? '0 : err_q;
          res_q.iterations     <= step_q;
        end
      end
      default: ;
    endcase
  end

  assign stat_o.f_zero     = f_zero_q;
  assign stat_o.no_sign    = !fl_zero_q && !f_zero_q && (fl_neg_q == f_neg_q);
  assign stat_o.need_div   = pct_q && (mid_q != 32'sd0);
  assign stat_o.div_ovf    = ovf;
  assign stat_o.err_le_tol = err_q <= tol_q;
  assign stat_o.cap_hit    = step_q >= 7'(MAX_ITER);
  assign res_o             = res_q;

endmodule

// ----- hw/rtl/brf_ctrl.sv -----
// controller state machine: sequences cube evaluations, bisection steps and division
// depends on brf_pkg
`timescale 1ns / 1ps
module brf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  brf_pkg::dp_stat_t stat_i,
  output brf_pkg::dp_cmd_t  cmd_o,
  output logic              busy,
  output logic              done_o
);
  import brf_pkg::*;

  ctrl_state_e state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        done_q, done_d;

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_SQ;
          phase_d = PH_A;
        end
      end
      S_SQ:     state_d = S_HI;
      S_HI:     state_d = S_LO;
      S_LO:     state_d = S_CUBE;
      S_CUBE:   state_d = S_POLY;
      S_POLY: begin
        case (phase_q)
          PH_A:    state_d = S_SAVE_A;
          PH_B:    state_d = S_CHECK;
          default: state_d = S_UPDATE;
        endcase
      end
      S_SAVE_A: begin
        state_d = S_SQ;
        phase_d = PH_B;
      end
      S_CHECK: begin
        state_d = stat_i.no_sign ? S_IDLE : S_SQ;
        phase_d = PH_M;
      end
      S_UPDATE: begin
        if (stat_i.f_zero) begin
          state_d = S_IDLE;
        end else begin
          state_d = stat_i.need_div ? S_DIV_INIT : S_JUDGE;
        end
      end
      S_DIV_INIT: begin
        cnt_d   = '0;
        state_d = stat_i.div_ovf ? S_JUDGE : S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DIV_STEPS - 1)) begin
          state_d = S_JUDGE;
        end
      end
      S_JUDGE: begin
        state_d = (stat_i.err_le_tol || stat_i.cap_hit) ? S_IDLE : S_SQ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.code = ST_CONVERGED;
    done_d     = 1'b0;
    case (state_q)
      S_IDLE:     if (start) cmd_o.op = OP_LOAD;
      S_SQ:       cmd_o.op = OP_SQ;
      S_HI:       cmd_o.op = OP_HI;
      S_LO:       cmd_o.op = OP_LO;
      S_CUBE:     cmd_o.op = OP_CUBE;
      S_POLY:     cmd_o.op = OP_POLY;
      S_SAVE_A:   cmd_o.op = OP_SAVE_A;
      S_CHECK: begin
        if (stat_i.no_sign) begin
          cmd_o.op   = OP_FINISH;
          cmd_o.code = ST_NO_SIGN;
          done_d     = 1'b1;
        end else begin
          cmd_o.op = OP_MID;
        end
      end
      S_UPDATE: begin
        if (stat_i.f_zero) begin
          cmd_o.op   = OP_FINISH;
          cmd_o.code = ST_EXACT;
          done_d     = 1'b1;
        end else begin
          cmd_o.op = OP_UPDATE;
        end
      end
      S_DIV_INIT: cmd_o.op = OP_DIV_INIT;
      S_DIV_STEP: cmd_o.op = OP_DIV_STEP;
      S_JUDGE: begin
        if (stat_i.err_le_tol) begin
          cmd_o.op   = OP_FINISH;
          cmd_o.code = ST_CONVERGED;
          done_d     = 1'b1;
        end else if (stat_i.cap_hit) begin
          cmd_o.op   = OP_FINISH;
          cmd_o.code = ST_CAP;
          done_d     = 1'b1;
        end else begin
          cmd_o.op = OP_MID;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_A;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ----- hw/rtl/bisection_root_finder.sv -----
// top level of the bisection root finder for f(x) = x^3 - 7x + 1
// depends on brf_pkg, brf_ctrl, brf_dp
`timescale 1ns / 1ps
// a beat is taken when start is high while busy is low; busy then stays high
// for the whole search and no further beat is taken. the result beat shows on
// res_o with done_o high for exactly one cycle, in the first cycle with busy low
// again, and the receiver cannot stall it. timing is set by a single shared 32x32
// multiplier, which evaluates each cubic through the square, high, low, cube and
// polynomial steps, and by a one-bit-a-cycle restoring divider for the percent
// error, which is skipped when the quotient saturates or the midpoint is zero. an
// interval with no sign change ends the search once the cubic is known at both
// ends; otherwise each bisection step evaluates the cubic at the midpoint, and the
// search stops after at most MAX_ITER steps.
module bisection_root_finder #(
  parameter int unsigned MAX_ITER  = brf_pkg::MAX_ITER_DEF,
  parameter int unsigned FRAC_BITS = brf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  brf_pkg::in_beat_t  in_i,
  output logic               busy,
  output logic               done_o,
  output brf_pkg::res_beat_t res_o
);
  import brf_pkg::*;

  // command and status between controller and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  brf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  brf_dp #(
    .MAX_ITER  (MAX_ITER),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res_o)
  );

  // a result beat always closes a search
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat without a search");

  // a search only opens on a start
  a_busy_from_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // step count never goes past the cap
  a_iter_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.iterations <= 7'(MAX_ITER)))
    else $error("iteration count beyond cap");

  // no sign change reports no steps and no root
  a_no_sign_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_NO_SIGN) |-> (res_o.iterations == 7'd0 &&
      res_o.root == 32'sd0))
    else $error("no sign change beat carries data");

endmodule

// ----- tb/bisection_root_finder_checker.sv -----
// checker of the bisection root finder test: predicts each result beat from the accepted
// command beat and compares it field by field. depends on brf_pkg
`timescale 1ns / 1ps
module bisection_root_finder_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  brf_pkg::in_beat_t  in_i,
  input  logic               done_o,
  input  brf_pkg::res_beat_t res_o,
  output int                 fail_count,
  output int                 pending
);
  import brf_pkg::*;

  localparam int          ITER_CAP = MAX_ITER_DEF;
  localparam int          FB       = FRAC_BITS_DEF;
  localparam longint unsigned CUBE_LIMIT = 64'd1 << 62;

  res_beat_t expected_roots[$];

  // search state of the predictor
  longint lo_end, hi_end, mid_pt, prev_mid, f_at_lo;
  int     steps;

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  // f(x) = x^3 - 7x + 1 with the block's truncation and cube saturation
  function automatic longint cubic_at(longint x);
    longint unsigned ax, sq, sq_hi, sq_lo, p_hi, p_lo, cube_mag;
    longint cube;
    ax = abs64(x);
    sq = (ax * ax) >> FB;
    sq_hi = sq >> 32;
    sq_lo = sq & 64'hFFFF_FFFF;
    p_hi = sq_hi * ax;
    p_lo = sq_lo * ax;
    if (p_hi >= (64'd1 << (FB - 2))) begin
      cube_mag = CUBE_LIMIT;
    end else begin
      cube_mag = (p_hi << (32 - FB)) + (p_lo >> FB);
      if (cube_mag > CUBE_LIMIT) cube_mag = CUBE_LIMIT;
    end
    cube = (x < 0) ? -longint'(cube_mag) : longint'(cube_mag);
    return cube - 7 * x + (longint'(1) << FB);
  endfunction

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic longint unsigned percent_err(longint unsigned d, longint c);
    longint unsigned q, ac, ip, rm, r;
    q = d * 100;
    ac = abs64(c);
    if (ac == 0) return (q > ERR_MAX) ? ERR_MAX : q;
    ip = q / ac;
    rm = q % ac;
    if (ip >= (64'd1 << (31 - FB))) return ERR_MAX;
    r = (ip << FB) + ((rm << FB) / ac);
    return (r > ERR_MAX) ? ERR_MAX : r;
  endfunction

  function automatic res_beat_t bisect(in_beat_t cmd);
    res_beat_t r;
    longint fc;
    longint unsigned d, err;
    status_e st;
    r = '0;
    if (sign_of(cubic_at(cmd.left_end)) * sign_of(cubic_at(cmd.right_end)) > 0) begin
      r.status = ST_NO_SIGN;
      return r;
    end
    lo_end = cmd.left_end;
    hi_end = cmd.right_end;
    prev_mid = cmd.left_end;
    steps = 0;
    err = 0;
    forever begin
      steps++;
      mid_pt = (lo_end + hi_end) >>> 1;
      fc = cubic_at(mid_pt);
      if (fc == 0) begin
        err = 0;
        st = ST_EXACT;
        break;
      end
      f_at_lo = cubic_at(lo_end);
      if (sign_of(f_at_lo) * sign_of(fc) < 0) hi_end = mid_pt;
      else lo_end = mid_pt;
      d = abs64(mid_pt - prev_mid);
      if (cmd.error_mode) err = percent_err(d, mid_pt);
      else err = (d > ERR_MAX) ? ERR_MAX : d;
      prev_mid = mid_pt;
      if (err <= cmd.tolerance) begin
        st = ST_CONVERGED;
        break;
      end
      if (steps >= ITER_CAP) begin
        st = ST_CAP;
        break;
      end
    end
    r.root = mid_pt[31:0];
    r.error_estimate = err[30:0];
    r.iterations = steps[6:0];
    r.status = st;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_beat_t want;
    if (!rst_ni) begin
      expected_roots.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (done_o) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected result beat, status", res_o.status, -1);
        end else begin
          want = expected_roots.pop_front();
          if (res_o.root !== want.root) report_mismatch("root", res_o.root, want.root);
          if (res_o.error_estimate !== want.error_estimate)
            report_mismatch("error_estimate", res_o.error_estimate, want.error_estimate);
          if (res_o.iterations !== want.iterations)
            report_mismatch("iterations", res_o.iterations, want.iterations);
          if (res_o.status !== want.status)
            report_mismatch("status", res_o.status, want.status);
        end
      end
      if (start && !busy) expected_roots.push_back(bisect(in_i));
      pending = expected_roots.size();
    end
  end

endmodule

// ----- tb/bisection_root_finder_test.sv -----
// top of the bisection root finder test: clock, reset, command stimulus and verdict
// depends on brf_pkg, bisection_root_finder and bisection_root_finder_checker
`timescale 1ns / 1ps
module bisection_root_finder_test;
  import brf_pkg::*;

  localparam int     RANDOM_BEATS = 600;
  localparam longint CYCLE_LIMIT  = 8_000_000;
  localparam int     ONE          = 1 << FRAC_BITS_DEF;
  // rough positions of the three real roots in Q8.24
  localparam int     ROOT_NEG     = -45_813_000;
  localparam int     ROOT_MID     = 2_400_800;
  localparam int     ROOT_POS     = 43_413_000;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  in_beat_t  in_i;
  logic      busy;
  logic      done_o;
  res_beat_t res_o;
  int        fail_count;
  int        pending;
  longint    cycles;

  bisection_root_finder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .in_i   (in_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  bisection_root_finder_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog: a hung search or a lost result ends the run here
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bisection_root_finder test failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one, and runs with none at all
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drive one command beat and hold it until the block takes it
  task automatic send_beat(int lft, int rgt, int tol, bit pct, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i.left_end <= lft;
    in_i.right_end <= rgt;
    in_i.tolerance <= tol[30:0];
    in_i.error_mode <= pct;
    do @(posedge clk_i); while (busy);
  endtask

  // stop sending and wait until every expected result beat has come
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // a bracket around one root with random width, sometimes given reversed
  task automatic send_bracket(int gap);
    int centre, below, above, tol, pick;
    bit pct;
    pick = $urandom_range(0, 2);
    centre = (pick == 0) ? ROOT_NEG : ((pick == 1) ? ROOT_MID : ROOT_POS);
    below = $urandom_range(1 << 14, ONE / 2);
    above = $urandom_range(1 << 14, ONE / 2);
    pct = $urandom_range(0, 1);
    // tolerance spread over many magnitudes, rarely zero so the search runs until the midpoint stops moving
    if ($urandom_range(0, 49) == 0) tol = 0;
    else tol = $urandom_range(1, 1 << $urandom_range(4, 24));
    if ($urandom_range(0, 3) == 0)
      send_beat(centre + above, centre - below, tol, pct, gap);
    else
      send_beat(centre - below, centre + above, tol, pct, gap);
  endtask

  initial begin
    int tol;
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats
    send_beat(0, ONE, 0, 1'b0, 0);                        // middle root, zero tolerance
    send_beat(2 * ONE, 3 * ONE, ERR_MAX, 1'b0, 0);        // huge tolerance: one step
    send_beat(-3 * ONE, -2 * ONE, 256, 1'b0, 1);          // negative root, absolute
    send_beat(-3 * ONE, -2 * ONE, ONE / 1000, 1'b1, 0);   // negative root, percent
    send_beat(3 * ONE, 4 * ONE, 5, 1'b0, 2);              // no sign change
    send_beat(-ONE, ONE, 1000, 1'b1, 0);                  // first midpoint at zero in percent
    send_beat(-ONE, ONE, 1000, 1'b0, 0);
    send_beat(ONE, 0, 64, 1'b1, 0);                       // reversed interval
    send_beat(-3 * ONE, 3 * ONE, 0, 1'b1, 0);             // three roots, percent, zero tolerance
    send_beat(32'sh8000_0000, 32'sh7FFF_FFFF, 1 << 20, 1'b0, 0);  // full range, saturated cube
    send_beat(32'sh8000_0000, 32'sh7FFF_FFFF, 1 << 20, 1'b1, 3);
    send_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1'b0, 0);         // point interval, no change
    send_beat(32'sh8000_0000, 32'sh8000_0000, ERR_MAX, 1'b1, 0);
    send_beat(ROOT_MID - 1000, ROOT_MID + 1000, 1, 1'b0, 0);       // tight bracket
    send_beat(ROOT_POS - ONE, ROOT_POS + ONE, ERR_MAX, 1'b1, 0);
    send_beat(0, 0, 0, 1'b0, 0);                                   // f(0) = 1, no change

    // random beats: most are real brackets, the rest raw noise over every bit
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 2) wait_drained();   // let the block go fully idle once
      if ($urandom_range(0, 4) != 0) begin
        send_bracket(pick_gap());
      end else begin
        tol = $urandom() >> $urandom_range(1, 31);
        send_beat($urandom(), $urandom(), tol, $urandom_range(0, 1), pick_gap());
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("bisection_root_finder test passed");
    end else begin
      $display("bisection_root_finder test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/brf_pkg.sv
hw/rtl/brf_dp.sv
hw/rtl/brf_ctrl.sv
hw/rtl/bisection_root_finder.sv
tb/bisection_root_finder_checker.sv
tb/bisection_root_finder_test.sv
